@@ src/lbc_pkg.sv @@
// Package for the LRU block cache: sizes, outcome codes and the structs
// that pass between the top level and the row of entry cells.
// No dependencies.
package lbc_pkg;
  localparam int ENTRIES     = 16;
  localparam int BLOCK_WORDS = 128;
  localparam int SLOT_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W       = $clog2(ENTRIES + 1);
  localparam int ADDR_W      = (ENTRIES * BLOCK_WORDS > 1) ?
                               $clog2(ENTRIES * BLOCK_WORDS) : 1;
  localparam int TAG_W       = 64;
  localparam int STAMP_W     = 32;
  localparam int WIDX_W      = 7;
  localparam int DATA_W      = 64;
  localparam int OUTC_W      = 2;
  localparam int SLOT_OUT_W  = 4;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic [OUTC_W-1:0] OUTC_MISS  = 2'd0;
  localparam logic [OUTC_W-1:0] OUTC_HIT   = 2'd1;
  localparam logic [OUTC_W-1:0] OUTC_FILL  = 2'd2;
  localparam logic [OUTC_W-1:0] OUTC_EVICT = 2'd3;

  // Running minimum carried down the row of cells
  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [SLOT_W-1:0]  idx;
  } cand_t;

  // Update of one entry at the end of an item
  typedef struct packed {
    logic               stamp_we;
    logic               tag_we;
    logic [TAG_W-1:0]   node_tag;
    logic [TAG_W-1:0]   block_tag;
    logic [STAMP_W-1:0] stamp;
  } upd_t;
endpackage

@@ src/lbc_cell.sv @@
// One cache entry: valid bit, tags and use stamp, tag compare, and one
// stage of the least-recently-used search chain.
// Depends on lbc_pkg.
module lbc_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [lbc_pkg::SLOT_W-1:0]      idx,
  input  logic [lbc_pkg::TAG_W-1:0]       key_node,
  input  logic [lbc_pkg::TAG_W-1:0]       key_block,
  input  lbc_pkg::upd_t                   upd,
  input  lbc_pkg::cand_t                  cand_in,
  output lbc_pkg::cand_t                  cand_out,
  output logic                            valid,
  output logic                            match
);
  logic                          valid_r;
  logic [lbc_pkg::TAG_W-1:0]     node_r;
  logic [lbc_pkg::TAG_W-1:0]     block_r;
  logic [lbc_pkg::STAMP_W-1:0]   stamp_r;
  lbc_pkg::cand_t                cand_r;
  lbc_pkg::cand_t                cand_nxt;

  // Hold state, take updates from the controller
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      stamp_r <= '0;
    end else begin
      if (upd.tag_we) valid_r <= 1'b1;
      if (upd.stamp_we) stamp_r <= upd.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.tag_we) begin
      node_r  <= upd.node_tag;
      block_r <= upd.block_tag;
    end
  end

  // Keep own stamp when not larger, so ties go to the higher index
  always_comb begin
    if (stamp_r <= cand_in.stamp) begin
      cand_nxt.stamp = stamp_r;
      cand_nxt.idx   = idx;
    end else begin
      cand_nxt = cand_in;
    end
  end

  // Advance the search chain every cycle
  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
  end

  assign cand_out = cand_r;
  assign valid    = valid_r;
  assign match    = valid_r && (node_r == key_node) && (block_r == key_block);
endmodule

@@ src/lru_block_cache.sv @@
// Top level of the LRU block cache: command interface, controller, the
// row of entry cells and the block word memory.
// Depends on lbc_pkg and lbc_cell.
//
//  channel | ports                                         | handshake
//  input   | in_opcode in_node_id in_block_id              | start & !busy
//          | in_word_index in_write_data                   |
//  result  | out_outcome out_slot out_read_data            | out_valid strobe
//
// After the accepting edge busy stays high while the controller passes through
// ST_SCAN, where the minimum-stamp search runs down the row of cells,
// ST_DONE, which updates the entry and accesses the word memory, and ST_OUT,
// which presents the result. The next beat is taken once it is back in ST_IDLE.
// Synchronous active-low reset clears valid bits, stamps and use counter.
// The receiver cannot stall; each result shows for exactly one cycle.
module lru_block_cache (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_opcode,
  input  logic [lbc_pkg::TAG_W-1:0]         in_node_id,
  input  logic [lbc_pkg::TAG_W-1:0]         in_block_id,
  input  logic [lbc_pkg::WIDX_W-1:0]        in_word_index,
  input  logic [lbc_pkg::DATA_W-1:0]        in_write_data,
  output logic                              out_valid,
  output logic [lbc_pkg::OUTC_W-1:0]        out_outcome,
  output logic [lbc_pkg::SLOT_OUT_W-1:0]    out_slot,
  output logic [lbc_pkg::DATA_W-1:0]        out_read_data
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  localparam int N = lbc_pkg::ENTRIES;

  logic [1:0]                      state_r, state_nxt;
  logic [lbc_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [lbc_pkg::STAMP_W-1:0]     use_cnt_r;
  logic                            op_r;
  logic [lbc_pkg::TAG_W-1:0]       node_r, block_r;
  logic [lbc_pkg::WIDX_W-1:0]      widx_r;
  logic [lbc_pkg::DATA_W-1:0]      wdata_r;
  logic [lbc_pkg::OUTC_W-1:0]      outc_r;
  logic [lbc_pkg::SLOT_W-1:0]      slot_r;
  logic                            rd_en_r;

  lbc_pkg::upd_t                   upd [N];
  lbc_pkg::cand_t                  cand [N+1];
  logic [N-1:0]                    valid_v, match_v;

  logic                            hit, free_found, word_ok;
  logic [lbc_pkg::SLOT_W-1:0]      hit_idx, free_idx, target;
  logic [lbc_pkg::OUTC_W-1:0]      outc;
  logic                            accept, finish;

  logic [lbc_pkg::DATA_W-1:0]      mem [lbc_pkg::ENTRIES * lbc_pkg::BLOCK_WORDS];
  logic [lbc_pkg::DATA_W-1:0]      mem_q;
  logic [lbc_pkg::ADDR_W-1:0]      addr;
  logic                            mem_we;

  assign accept = start && !busy;
  assign finish = (state_r == ST_DONE);
  assign busy   = (state_r != ST_IDLE);

  // Sequence one item through scan, update and result
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (start) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == lbc_pkg::CNT_W'(N - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: state_nxt = ST_OUT;
      ST_OUT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      use_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (accept) use_cnt_r <= use_cnt_r + 1'b1;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_opcode;
      node_r  <= in_node_id;
      block_r <= in_block_id;
      widx_r  <= in_word_index;
      wdata_r <= in_write_data;
    end
  end

  // Row of entry cells; the chain starts with the largest stamp
  assign cand[0].stamp = '1;
  assign cand[0].idx   = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    always_comb begin
      upd[i].node_tag  = node_r;
      upd[i].block_tag = block_r;
      upd[i].stamp     = use_cnt_r;
      upd[i].stamp_we  = finish && (outc != lbc_pkg::OUTC_MISS) &&
                         (target == lbc_pkg::SLOT_W'(i));
      upd[i].tag_we    = finish && (outc != lbc_pkg::OUTC_MISS) &&
                         (outc != lbc_pkg::OUTC_HIT) &&
                         (target == lbc_pkg::SLOT_W'(i));
    end

    lbc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .idx       (lbc_pkg::SLOT_W'(i)),
      .key_node  (node_r),
      .key_block (block_r),
      .upd       (upd[i]),
      .cand_in   (cand[i]),
      .cand_out  (cand[i+1]),
      .valid     (valid_v[i]),
      .match     (match_v[i])
    );
  end

  // Pick the lowest matching entry and the lowest free entry
  always_comb begin
    hit        = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < N; i++) begin
      if (!hit && match_v[i]) begin
        hit     = 1'b1;
        hit_idx = lbc_pkg::SLOT_W'(i);
      end
      if (!free_found && !valid_v[i]) begin
        free_found = 1'b1;
        free_idx   = lbc_pkg::SLOT_W'(i);
      end
    end
  end

  // Decide outcome and target entry
  always_comb begin
    if (hit) begin
      outc   = lbc_pkg::OUTC_HIT;
      target = hit_idx;
    end else if (op_r == lbc_pkg::OP_GET) begin
      outc   = lbc_pkg::OUTC_MISS;
      target = '0;
    end else if (free_found) begin
      outc   = lbc_pkg::OUTC_FILL;
      target = free_idx;
    end else begin
      outc   = lbc_pkg::OUTC_EVICT;
      target = cand[N].idx;
    end
  end

  assign word_ok = ({1'b0, widx_r} < (lbc_pkg::WIDX_W+1)'(lbc_pkg::BLOCK_WORDS));
  assign addr    = lbc_pkg::ADDR_W'(32'(target) * 32'(lbc_pkg::BLOCK_WORDS) +
                                    32'(widx_r));
  assign mem_we  = finish && word_ok && (op_r == lbc_pkg::OP_PUT);

  // Block word memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[addr] <= wdata_r;
    mem_q <= mem[addr];
  end

  // Hold the result for the output cycle
  always_ff @(posedge clk) begin
    if (finish) begin
      outc_r  <= outc;
      slot_r  <= target;
      rd_en_r <= hit && (op_r == lbc_pkg::OP_GET) && word_ok;
    end
  end

  assign out_valid     = (state_r == ST_OUT);
  assign out_outcome   = outc_r;
  assign out_slot      = lbc_pkg::SLOT_OUT_W'(slot_r);
  assign out_read_data = rd_en_r ? mem_q : '0;
endmodule

@@ tb/lru_block_cache_chk.sv @@
// Checker for the LRU block cache: watches the command and result beats,
// predicts each result from its own copy of the cache state and compares.
// Depends on lbc_pkg.
`timescale 1ns / 1ps
module lru_block_cache_chk (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             busy,
  input  logic                             in_opcode,
  input  logic [lbc_pkg::TAG_W-1:0]        in_node_id,
  input  logic [lbc_pkg::TAG_W-1:0]        in_block_id,
  input  logic [lbc_pkg::WIDX_W-1:0]       in_word_index,
  input  logic [lbc_pkg::DATA_W-1:0]       in_write_data,
  input  logic                             out_valid,
  input  logic [lbc_pkg::OUTC_W-1:0]       out_outcome,
  input  logic [lbc_pkg::SLOT_OUT_W-1:0]   out_slot,
  input  logic [lbc_pkg::DATA_W-1:0]       out_read_data,
  output int                               fail_count,
  output int                               pending_count,
  output int                               hit_total,
  output int                               evict_total
);
  typedef struct packed {
    logic [lbc_pkg::OUTC_W-1:0]     outcome;
    logic [lbc_pkg::SLOT_OUT_W-1:0] slot;
    logic [lbc_pkg::DATA_W-1:0]     rdata;
  } lookup_res_t;

  logic                        line_valid [lbc_pkg::ENTRIES];
  logic [lbc_pkg::TAG_W-1:0]   line_node  [lbc_pkg::ENTRIES];
  logic [lbc_pkg::TAG_W-1:0]   line_block [lbc_pkg::ENTRIES];
  logic [lbc_pkg::STAMP_W-1:0] line_stamp [lbc_pkg::ENTRIES];
  logic [lbc_pkg::DATA_W-1:0]  word_mem   [lbc_pkg::ENTRIES*lbc_pkg::BLOCK_WORDS];
  logic [lbc_pkg::STAMP_W-1:0] access_count;
  lookup_res_t                 lookup_q [$];

  assign pending_count = lookup_q.size();

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Work out the result of one command and update the predicted state
  function automatic lookup_res_t cache_access(input logic op,
      input logic [lbc_pkg::TAG_W-1:0] nid, input logic [lbc_pkg::TAG_W-1:0] bid,
      input logic [lbc_pkg::WIDX_W-1:0] widx, input logic [lbc_pkg::DATA_W-1:0] wdata);
    lookup_res_t r;
    int tgt;
    bit hit;
    bit found;
    logic [lbc_pkg::STAMP_W-1:0] best;
    r = '0;
    tgt = 0;
    hit = 1'b0;
    found = 1'b0;
    access_count = access_count + 1'b1;
    for (int i = 0; i < lbc_pkg::ENTRIES; i++)
      if (!hit && line_valid[i] && line_node[i] == nid && line_block[i] == bid) begin
        hit = 1'b1;
        tgt = i;
      end
    if (hit) begin
      line_stamp[tgt] = access_count;
      r.outcome = lbc_pkg::OUTC_HIT;
      if (op == lbc_pkg::OP_GET) begin
        if (widx < lbc_pkg::BLOCK_WORDS)
          r.rdata = word_mem[tgt*lbc_pkg::BLOCK_WORDS + widx];
      end else if (widx < lbc_pkg::BLOCK_WORDS) begin
        word_mem[tgt*lbc_pkg::BLOCK_WORDS + widx] = wdata;
      end
    end else if (op == lbc_pkg::OP_GET) begin
      r.outcome = lbc_pkg::OUTC_MISS;
    end else begin
      for (int i = 0; i < lbc_pkg::ENTRIES; i++)
        if (!found && !line_valid[i]) begin
          found = 1'b1;
          tgt = i;
        end
      if (found) begin
        r.outcome = lbc_pkg::OUTC_FILL;
      end else begin
        // smallest stamp, ties go to the highest index
        best = line_stamp[0];
        for (int i = 0; i < lbc_pkg::ENTRIES; i++)
          if (line_stamp[i] <= best) begin
            best = line_stamp[i];
            tgt = i;
          end
        r.outcome = lbc_pkg::OUTC_EVICT;
      end
      line_valid[tgt] = 1'b1;
      line_node[tgt]  = nid;
      line_block[tgt] = bid;
      line_stamp[tgt] = access_count;
      if (widx < lbc_pkg::BLOCK_WORDS) word_mem[tgt*lbc_pkg::BLOCK_WORDS + widx] = wdata;
    end
    r.slot = tgt[lbc_pkg::SLOT_OUT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_res_t want;
    if (!rst_n) begin
      for (int i = 0; i < lbc_pkg::ENTRIES; i++) begin
        line_valid[i] = 1'b0;
        line_stamp[i] = '0;
      end
      access_count = '0;
      lookup_q.delete();
    end else begin
      // Check result beats against the oldest expectation
      if (out_valid) begin
        if (lookup_q.size() == 0) begin
          report_mismatch("unexpected result", {62'd0, out_outcome}, 64'd0);
        end else begin
          want = lookup_q.pop_front();
          if (out_outcome != want.outcome)
            report_mismatch("outcome", 64'(out_outcome), 64'(want.outcome));
          if (out_slot != want.slot)
            report_mismatch("slot", 64'(out_slot), 64'(want.slot));
          if (out_read_data != want.rdata)
            report_mismatch("read_data", out_read_data, want.rdata);
          if (want.outcome == lbc_pkg::OUTC_HIT) hit_total++;
          if (want.outcome == lbc_pkg::OUTC_EVICT) evict_total++;
        end
      end
      // Predict on every accepted command beat
      if (start && !busy)
        lookup_q.push_back(cache_access(in_opcode, in_node_id, in_block_id,
                                        in_word_index, in_write_data));
    end
  end

  initial begin
    fail_count = 0;
    hit_total = 0;
    evict_total = 0;
  end
endmodule

@@ tb/lru_block_cache_tb.sv @@
// Testbench top for the LRU block cache: clock, reset, command stimulus
// with bursts and gaps, and the verdict. Depends on lbc_pkg,
// lru_block_cache and lru_block_cache_chk.
`timescale 1ns / 1ps
module lru_block_cache_tb;
  localparam int RANDOM_ITEMS = 1800;
  localparam int POOL_SIZE    = 24;
  localparam int LOW_WORDS    = 8;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  logic                           in_opcode;
  logic [lbc_pkg::TAG_W-1:0]      in_node_id;
  logic [lbc_pkg::TAG_W-1:0]      in_block_id;
  logic [lbc_pkg::WIDX_W-1:0]     in_word_index;
  logic [lbc_pkg::DATA_W-1:0]     in_write_data;
  logic                           out_valid;
  logic [lbc_pkg::OUTC_W-1:0]     out_outcome;
  logic [lbc_pkg::SLOT_OUT_W-1:0] out_slot;
  logic [lbc_pkg::DATA_W-1:0]     out_read_data;
  int                             fail_count;
  int                             pending_count;
  int                             hit_total;
  int                             evict_total;
  int                             sent_total;

  // Tag pool and a record of which words of each pooled block were written
  logic [lbc_pkg::TAG_W-1:0] pool_node  [POOL_SIZE];
  logic [lbc_pkg::TAG_W-1:0] pool_block [POOL_SIZE];
  bit                        pool_word_set [POOL_SIZE][lbc_pkg::BLOCK_WORDS];

  lru_block_cache i_dut (.*);

  lru_block_cache_chk i_chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Send one command beat and hold it until accepted
  task automatic send_cmd(input logic op, input logic [lbc_pkg::TAG_W-1:0] nid,
                          input logic [lbc_pkg::TAG_W-1:0] bid,
                          input logic [lbc_pkg::WIDX_W-1:0] widx,
                          input logic [lbc_pkg::DATA_W-1:0] wdata);
    start         <= 1'b1;
    in_opcode     <= op;
    in_node_id    <= nid;
    in_block_id   <= bid;
    in_word_index <= widx;
    in_write_data <= wdata;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_total++;
  endtask

  task automatic idle_gap(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Pooled access: a get only touches low words, which every slot holds
  // since the preload pass (a miss is fine if the block was evicted)
  task automatic pool_access(input int p, input bit want_put);
    int w;
    bit rd_ok;
    w = (($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                                     : $urandom_range(0, 7));
    rd_ok = (w < LOW_WORDS) && pool_word_set[p][w];
    if (want_put || !rd_ok) begin
      send_cmd(lbc_pkg::OP_PUT, pool_node[p], pool_block[p], w[lbc_pkg::WIDX_W-1:0],
               {$urandom, $urandom});
      if (w < lbc_pkg::BLOCK_WORDS) pool_word_set[p][w] = 1'b1;
    end else begin
      send_cmd(lbc_pkg::OP_GET, pool_node[p], pool_block[p], w[lbc_pkg::WIDX_W-1:0],
               {$urandom, $urandom});
    end
  endtask

  initial begin
    int burst;
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_opcode     <= lbc_pkg::OP_GET;
    in_node_id    <= '0;
    in_block_id   <= '0;
    in_word_index <= '0;
    in_write_data <= '0;
    sent_total = 0;
    // Extreme tags sit in the first pool entries, all bits get both values
    for (int p = 0; p < POOL_SIZE; p++) begin
      pool_node[p]  = {$urandom, $urandom};
      pool_block[p] = {$urandom, $urandom};
      for (int w = 0; w < lbc_pkg::BLOCK_WORDS; w++) pool_word_set[p][w] = 1'b0;
    end
    pool_node[0]  = '0;
    pool_block[0] = '0;
    pool_node[1]  = '1;
    pool_block[1] = '1;
    pool_node[2]  = '0;
    pool_block[2] = '1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: get miss on an empty cache, extreme fields, last word of a block
    send_cmd(lbc_pkg::OP_GET, '0, '0, '0, '0);
    send_cmd(lbc_pkg::OP_PUT, '0, '0, 7'd0, '1);
    pool_word_set[0][0] = 1'b1;
    send_cmd(lbc_pkg::OP_GET, '0, '0, 7'd0, '0);
    send_cmd(lbc_pkg::OP_PUT, '1, '1, 7'd127, '0);
    send_cmd(lbc_pkg::OP_GET, '1, '1, 7'd127, '1);
    send_cmd(lbc_pkg::OP_PUT, '1, '1, 7'd5, 64'hA5A5_5A5A_0F0F_F0F0);
    pool_word_set[1][5] = 1'b1;
    send_cmd(lbc_pkg::OP_GET, '1, '1, 7'd5, '0);
    send_cmd(lbc_pkg::OP_GET, '0, '1, 7'd1, '0);
    // Fill every free slot; the last puts and one more put evict the least recently used
    for (int p = 2; p < lbc_pkg::ENTRIES + 2; p++) pool_access(p, 1'b1);
    send_cmd(lbc_pkg::OP_PUT, 64'h1, 64'h2, 7'd3, 64'h1234);
    idle_gap(1);

    // Preload: fresh blocks evict in LRU order and write the low words of every slot
    for (int k = 0; k < lbc_pkg::ENTRIES; k++)
      for (int w = 0; w < LOW_WORDS; w++)
        send_cmd(lbc_pkg::OP_PUT, {32'h5EED_0000, 32'(k)}, {32'h0, 32'(k)},
                 lbc_pkg::WIDX_W'(w), {$urandom, $urandom});
    idle_gap(1);

    // Random: mostly a small working set around the cache size, some noise
    while (sent_total < RANDOM_ITEMS + 25) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst; k++) begin
        if ($urandom_range(0, 15) == 0)
          send_cmd(1'($urandom_range(0, 1)), {$urandom, $urandom}, {$urandom, $urandom},
                   lbc_pkg::WIDX_W'($urandom_range(0, 127)), {$urandom, $urandom});
        else
          pool_access($urandom_range(0, POOL_SIZE - 1), $urandom_range(0, 2) == 0);
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 30));
    end
    start <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (4 * (lbc_pkg::ENTRIES + 2)) @(posedge clk);
    $display("sent %0d commands: %0d hits and %0d LRU evictions checked",
             sent_total, hit_total, evict_total);
    if (fail_count == 0) begin
      $display("lru_block_cache_tb: PASS");
    end else begin
      $display("lru_block_cache_tb: FAIL");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest correct run
  initial begin
    #4_000_000;
    $display("lru_block_cache_tb: FAIL");
    $finish;
  end
endmodule

@@ filelist.f @@
src/lbc_pkg.sv
src/lbc_cell.sv
src/lru_block_cache.sv
tb/lru_block_cache_chk.sv
tb/lru_block_cache_tb.sv
